// ===== rtl/core/scrl_pkg.sv =====
`default_nettype none

package scrl_pkg;

  // Field and register widths.
  localparam int CMD_W   = 2;
  localparam int CODE_W  = 10;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 10;

  // Number of seen flags in the bitmap.
  localparam int CODE_COUNT = 1024;

  // Rank scale for the position mapping.
  localparam int RANK_SCALE = 1024;
  localparam int RANK_SHIFT = $clog2(RANK_SCALE);

  // The bitmap is stored as rows of ROW_W flags; a partial last row is allowed.
  localparam int ROW_W  = (CODE_COUNT >= 32) ? 32 : 16;
  localparam int BIT_W  = $clog2(ROW_W);
  localparam int ROWS   = (CODE_COUNT + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_CW = $clog2(ROWS + 1);

  // A code widened so that it can be compared against CODE_COUNT.
  localparam int CODE_X_W = ($clog2(CODE_COUNT + 1) > CODE_W) ? $clog2(CODE_COUNT + 1)
                                                               : CODE_W;
  localparam int RCMP_W   = CODE_X_W - BIT_W;

  // Serial divider: quotient of (lower * RANK_SCALE) / total.
  localparam int DIV_STEPS = COUNT_W + RANK_SHIFT;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  // Signed product of rank and span.
  localparam int PROD_W = COUNT_W + CFG_W + 1;

  // Stream widths.
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = CMD_W;
  localparam int OUT_TDATA_W = 40;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK   = 2'd1;

  // Configuration register indexes.
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] CFG_OUT_START = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_OUT_END   = 1'd1;

  localparam logic [CFG_W-1:0] OUT_START_RST = 10'd230;
  localparam logic [CFG_W-1:0] OUT_END_RST   = 10'd10;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [BIT_W:0] popcnt(input logic [ROW_W-1:0] w);
    logic [BIT_W:0] n;
    n = '0;
    for (int i = 0; i < ROW_W; i++) begin
      n = n + (BIT_W + 1)'(w[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scrl_ram.sv =====
`default_nettype none

module scrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic                                       rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/scrl_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Computes (dividend * RANK_SCALE) / divisor; the divisor must be nonzero.
module scrl_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire scrl_pkg::div_req_t req,
  output scrl_pkg::div_rsp_t      rsp
);

  import scrl_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CW-1:0]    cnt_r, cnt_nxt;
  logic [DIV_STEPS-1:0] num_r, num_nxt;
  logic [DIV_STEPS-1:0] q_r, q_nxt;
  logic [COUNT_W-1:0]   rem_r, rem_nxt;
  logic [COUNT_W-1:0]   dsr_r, dsr_nxt;
  logic [COUNT_W:0]     rem_sh;
  logic [COUNT_W:0]     rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_r, num_r[DIV_STEPS-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    ge      = rem_sh >= {1'b0, dsr_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = {req.dividend, {RANK_SHIFT{1'b0}}};
      q_nxt    = '0;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      q_nxt   = {q_r[DIV_STEPS-2:0], ge};
      num_nxt = {num_r[DIV_STEPS-2:0], 1'b0};
      cnt_nxt = cnt_r + DIV_CW'(1);
      if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r[COUNT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/seen_code_rank_linearizer_unit.sv =====
// Seen-code rank linearizer for a converter channel with blind zones.
//
// Input stream (in_*): one transaction per command. in_tuser carries the
// command (sample and map, mark only, or query), in_tdata the converter code.
// Every accepted transaction yields exactly one transaction on the output
// stream (out_*), which carries the mapped position, the count of seen codes
// below the code, the total count of seen codes and the prior seen flag.
// The user must write out_start and out_end through the configuration port
// only while the block is idle; the block itself does not enforce this.
//
// A command scans the bitmap one 32-flag RAM row per cycle, then passes a
// decision state. A sample with seen codes then runs a restoring divider,
// one quotient bit per cycle; every sample passes a multiply and an add state.
// in_tready is high only in idle, so a new transaction is accepted only once
// the previous one has completed.
//
// Reset clears the per-row valid flags, so the whole bitmap reads as unseen at
// once, and loads out_start = 230 and out_end = 10. A result that the receiver
// stalls stays in the output register; the next command is still accepted and
// processed, and waits for the output register to drain before it completes.

`default_nettype none

module seen_code_rank_linearizer_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input stream.
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // tdata: sample_code[9:0], zero padding [15:10]
  input  wire logic [scrl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: cmd[1:0]
  input  wire logic [scrl_pkg::IN_TUSER_W-1:0]    in_tuser,
  // Output stream.
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // tdata: position[9:0], rank_lower[20:10], total_seen[31:21], seen_bit[32],
  //        zero padding [39:33]
  output logic      [scrl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration write port.
  input  wire logic                               cfg_we,
  input  wire logic [scrl_pkg::CFG_AW-1:0]        cfg_addr,
  input  wire logic [scrl_pkg::CFG_W-1:0]         cfg_wdata
);

  import scrl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CMD_W-1:0]          cmd_r, cmd_nxt;
  logic [CODE_W-1:0]         code_r, code_nxt;
  logic [ROW_CW-1:0]         cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]        lower_r, lower_nxt;
  logic [COUNT_W-1:0]        total_r, total_nxt;
  logic                      prior_r, prior_nxt;
  logic [ROWS-1:0]           row_vld_r, row_vld_nxt;
  logic [COUNT_W-1:0]        v_r, v_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [CFG_W-1:0]          start_r, start_nxt;
  logic [CFG_W-1:0]          end_r, end_nxt;
  logic                      out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0]    out_data_r, out_data_nxt;

  // Bitmap RAM access.
  logic                      wr_en;
  logic [ROW_AW-1:0]         wr_addr;
  logic [ROW_W-1:0]          wr_data;
  logic                      rd_en;
  logic [ROW_AW-1:0]         rd_addr;
  logic [ROW_W-1:0]          rd_data;

  // Divider handshake.
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  // Scan datapath.
  logic [CODE_X_W-1:0]       code_x;
  logic                      in_map;
  logic [RCMP_W-1:0]         code_row;
  logic [BIT_W-1:0]          code_bit;
  logic [ROW_CW-1:0]         pr;
  logic [ROW_AW-1:0]         pr_idx;
  logic [RCMP_W-1:0]         pr_ext;
  logic                      row_hit;
  logic                      row_below;
  logic                      do_mark;
  logic [ROW_W-1:0]          bit_mask;
  logic [ROW_W-1:0]          word;
  logic [ROW_W-1:0]          word_m;
  logic [ROW_W-1:0]          low_word;

  // Mapping datapath.
  logic signed [CFG_W:0]     span;
  logic signed [PROD_W-1:0]  v_s;
  logic signed [PROD_W-1:0]  span_s;
  logic signed [PROD_W-1:0]  num;

  scrl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  scrl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    // The code's row and bit within the bitmap. A code past the end of the
    // bitmap lands beyond every stored row, so all seen flags count as lower.
    code_x   = CODE_X_W'(code_r);
    in_map   = code_x < CODE_X_W'(CODE_COUNT);
    code_row = code_x[CODE_X_W-1:BIT_W];
    code_bit = code_x[BIT_W-1:0];

    // The RAM data that arrives now belongs to the row read in the previous cycle.
    pr        = cnt_r - ROW_CW'(1);
    pr_idx    = pr[ROW_AW-1:0];
    pr_ext    = RCMP_W'(pr);
    row_hit   = (pr_ext == code_row);
    row_below = (pr_ext < code_row);
    bit_mask  = ROW_W'(1) << code_bit;
    word      = row_vld_r[pr_idx] ? rd_data : '0;
    do_mark   = ((cmd_r == CMD_SAMPLE) || (cmd_r == CMD_MARK)) && in_map && row_hit;
    word_m    = do_mark ? (word | bit_mask) : word;
    if (row_hit) begin
      low_word = word_m & (bit_mask - ROW_W'(1));
    end else if (row_below) begin
      low_word = word_m;
    end else begin
      low_word = '0;
    end

    span   = $signed({1'b0, end_r}) - $signed({1'b0, start_r});
    v_s    = $signed(PROD_W'(v_r));
    span_s = PROD_W'(span);
    num    = $signed({{(PROD_W - CFG_W - RANK_SHIFT){1'b0}}, start_r, {RANK_SHIFT{1'b0}}})
             + prod_r;

    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    code_nxt     = code_r;
    cnt_nxt      = cnt_r;
    lower_nxt    = lower_r;
    total_nxt    = total_r;
    prior_nxt    = prior_r;
    row_vld_nxt  = row_vld_r;
    v_nxt        = v_r;
    prod_nxt     = prod_r;
    pos_nxt      = pos_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;

    start_nxt = start_r;
    end_nxt   = end_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_OUT_START: start_nxt = cfg_wdata;
        CFG_OUT_END:   end_nxt   = cfg_wdata;
        default:       ;
      endcase
    end

    wr_en   = 1'b0;
    wr_addr = pr_idx;
    wr_data = word_m;
    rd_en   = 1'b0;
    rd_addr = cnt_r[ROW_AW-1:0];

    div_req.start    = 1'b0;
    div_req.dividend = lower_r;
    div_req.divisor  = total_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser[CMD_W-1:0];
          code_nxt  = in_tdata[CODE_W-1:0];
          cnt_nxt   = '0;
          lower_nxt = '0;
          total_nxt = '0;
          prior_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Read the row at cnt_r and accumulate the row that came back.
        rd_en = (cnt_r < ROW_CW'(ROWS));
        if (cnt_r != '0) begin
          total_nxt = total_r + COUNT_W'(popcnt(word_m));
          lower_nxt = lower_r + COUNT_W'(popcnt(low_word));
          if (row_hit && in_map) begin
            prior_nxt = word[code_bit];
          end
          if (do_mark) begin
            wr_en               = 1'b1;
            row_vld_nxt[pr_idx] = 1'b1;
          end
        end
        cnt_nxt = cnt_r + ROW_CW'(1);
        if (cnt_r == ROW_CW'(ROWS)) begin
          state_nxt = ST_CALC;
        end
      end

      ST_CALC: begin
        if (cmd_r != CMD_SAMPLE) begin
          pos_nxt   = '0;
          state_nxt = ST_DONE;
        end else if (total_r == '0) begin
          // With nothing seen the rank is zero and the position is out_start.
          v_nxt     = '0;
          state_nxt = ST_MUL;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          v_nxt     = div_rsp.quotient;
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_nxt  = v_s * span_s;
        state_nxt = ST_ADD;
      end

      ST_ADD: begin
        // The sum never goes negative for legal values; clamp anyway.
        pos_nxt   = num[PROD_W-1] ? '0 : num[RANK_SHIFT +: POS_W];
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {{(OUT_TDATA_W - POS_W - 2 * COUNT_W - 1){1'b0}},
                          prior_r, total_r, lower_r, pos_r};
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_vld_r <= '0;
      out_vld_r <= 1'b0;
      start_r   <= OUT_START_RST;
      end_r     <= OUT_END_RST;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      row_vld_r <= row_vld_nxt;
      out_vld_r <= out_vld_nxt;
      start_r   <= start_nxt;
      end_r     <= end_nxt;
      cnt_r     <= cnt_nxt;
    end
    cmd_r      <= cmd_nxt;
    code_r     <= code_nxt;
    lower_r    <= lower_nxt;
    total_r    <= total_nxt;
    prior_r    <= prior_nxt;
    v_r        <= v_nxt;
    prod_r     <= prod_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  // A command occupies the sequencer, so no second transaction follows at once.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a command is in flight");

  // The divider answers only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider result outside the divide state");

  // Codes counted below the sample are a subset of all seen codes.
  a_rank_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[POS_W +: COUNT_W] <= out_tdata[POS_W + COUNT_W +: COUNT_W]))
    else $error("rank_lower exceeds total_seen");

endmodule

`default_nettype wire

// ===== tb/tb_seen_code_rank_linearizer_unit.sv =====
module tb_seen_code_rank_linearizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import scrl_pkg::*;

  // The package names only the sample and mark commands. The query command
  // and the spare encoding, which must behave like a query, are named here.
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // The receiver holds off this long once, so that the block fills up. The
  // watchdog limit covers that stretch several times over, plus one sample
  // command.
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  // Worst case time from acceptance to result, used after the last result.
  localparam int DRAIN_CYCLES = 64;
  localparam int REPORT_MAX = 10;

  // One result transaction, split into its fields.
  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] rank_lower;
    logic [COUNT_W-1:0] total_seen;
    logic               seen_bit;
  } rank_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // sample_code[9:0], zero padding [15:10]
  logic [IN_TUSER_W-1:0]  in_tuser;   // cmd[1:0]
  logic                   out_tvalid;
  logic                   out_tready;
  // position[9:0], rank_lower[20:10], total_seen[31:21], seen_bit[32], padding [39:33]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_AW-1:0]      cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;

  seen_code_rank_linearizer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block: the seen bitmap and both mapping registers.
  logic seen_flags [CODE_COUNT];
  int   shadow_start;
  int   shadow_end;

  // Expected results in the order their commands were accepted.
  rank_result_t pending_results [$];

  // Control shared between the stimulus and the receiver.
  bit steady_flow;      // When set, neither side inserts idle cycles.
  bit long_hold;        // Asks the receiver for one long hold-off.

  // Bookkeeping for the checker and the closing summary.
  int mismatches;
  int n_sample, n_mark, n_query, n_writes, n_holds, n_checked;
  int peak_total;
  int quiet_cycles;

  // Works out the result of one command and applies its mark to the shadow
  // bitmap. The position is computed with exact integer arithmetic: the rank
  // is floor(lower * 1024 / total), and the span may be negative when the
  // mapping runs downward.
  function automatic rank_result_t rank_and_map(logic [CMD_W-1:0] cmd,
                                                logic [CODE_W-1:0] code);
    rank_result_t r;
    int           lower;
    int           total;
    longint       rank;
    longint       num;
    lower = 0;
    total = 0;
    r.seen_bit = seen_flags[code];
    if (cmd == CMD_SAMPLE || cmd == CMD_MARK) begin
      seen_flags[code] = 1'b1;
    end
    for (int i = 0; i < CODE_COUNT; i++) begin
      if (seen_flags[i]) begin
        total++;
        if (i < code) begin
          lower++;
        end
      end
    end
    r.rank_lower = COUNT_W'(lower);
    r.total_seen = COUNT_W'(total);
    r.position = '0;
    if (cmd == CMD_SAMPLE) begin
      rank = (total != 0) ? (longint'(lower) * RANK_SCALE) / total : 0;
      num = longint'(shadow_start) * RANK_SCALE
            + rank * (longint'(shadow_end) - longint'(shadow_start));
      if (num < 0) begin
        num = 0;
      end
      r.position = POS_W'(num / RANK_SCALE);
    end
    if (total > peak_total) begin
      peak_total = total;
    end
    return r;
  endfunction

  // Offers one command transaction. The task is entered and left at a falling
  // edge. Valid stays high on the way out, so that a back-to-back command does
  // not lower and raise it in the same time step; a gap lowers it instead.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [CODE_W-1:0] code);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_TDATA_W'(code);
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(rank_and_map(cmd, code));
    case (cmd)
      CMD_SAMPLE: n_sample++;
      CMD_MARK:   n_mark++;
      default:    n_query++;
    endcase
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected result has come back. Every
  // command yields a result, so the block is idle once the queue is empty.
  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Writes one mapping register. Only called while the block is idle.
  task automatic write_reg(logic [CFG_AW-1:0] addr, int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= CFG_W'(value);
    if (addr == CFG_OUT_START) begin
      shadow_start = value;
    end else begin
      shadow_end = value;
    end
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_mapping(int start_coord, int end_coord);
    wait_until_idle();
    write_reg(CFG_OUT_START, start_coord);
    write_reg(CFG_OUT_END, end_coord);
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return CMD_SAMPLE;
    if (r < 16) return CMD_MARK;
    if (r < 19) return CMD_QUERY;
    return CMD_SPARE;
  endfunction

  // Mostly uniform codes, the ends and middle of the range, and codes next
  // to the previous one mixed in so that already seen codes come up again.
  function automatic logic [CODE_W-1:0] pick_code(logic [CODE_W-1:0] prev);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 5))
        0: return '0;
        1: return CODE_W'(1);
        2: return '1;
        3: return '1 - CODE_W'(1);
        4: return CODE_W'(CODE_COUNT / 2);
        default: return CODE_W'(CODE_COUNT / 2 - 1);
      endcase
    end
    if (r < 3) begin
      return prev + CODE_W'($urandom_range(0, 4)) - CODE_W'(2);
    end
    return CODE_W'($urandom());
  endfunction

  // Commands on the reset mapping (230 down to 10), from an empty bitmap:
  // queries of unseen and seen codes, the spare command, samples at both
  // ends of the range and inside it, and marks of seen and unseen codes.
  task automatic test_reset_state();
    send_item(CMD_QUERY, 10'd0);
    send_item(CMD_SPARE, 10'd1023);
    send_item(CMD_SAMPLE, 10'd0);
    send_item(CMD_SAMPLE, 10'd1023);
    send_item(CMD_MARK, 10'd1023);
    send_item(CMD_QUERY, 10'd1023);
    send_item(CMD_SPARE, 10'd512);
    send_item(CMD_SAMPLE, 10'd512);
    send_item(CMD_MARK, 10'h155);
    send_item(CMD_SAMPLE, 10'h2AA);
    send_item(CMD_MARK, 10'h2AA);
    send_item(CMD_QUERY, 10'h155);
    send_item(CMD_SAMPLE, 10'd1);
  endtask

  // Mapping registers at their extremes, in both directions and with an
  // empty span at either end of the output range.
  task automatic test_register_extremes();
    set_mapping(0, 1023);
    send_item(CMD_SAMPLE, 10'd1023);
    send_item(CMD_SAMPLE, 10'd0);
    send_item(CMD_SAMPLE, 10'd600);
    set_mapping(1023, 0);
    send_item(CMD_SAMPLE, 10'd1023);
    send_item(CMD_SAMPLE, 10'd0);
    send_item(CMD_SAMPLE, 10'd600);
    set_mapping(0, 0);
    send_item(CMD_SAMPLE, 10'd700);
    set_mapping(1023, 1023);
    send_item(CMD_SAMPLE, 10'd800);
  endtask

  // Random commands in several phases, with a new mapping for each phase.
  task automatic test_random_traffic();
    logic [CODE_W-1:0] code;
    code = '0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_mapping(1023, 0);
        1: set_mapping(0, 1023);
        default: set_mapping($urandom_range(0, 1023), $urandom_range(0, 1023));
      endcase
      repeat (80) begin
        code = pick_code(code);
        send_item(pick_cmd(), code);
      end
    end
  endtask

  // A calibration restore: a run of mark commands over a window of codes,
  // followed by queries and samples in and around that window.
  task automatic test_calibration_restore();
    logic [CODE_W-1:0] base;
    int                span;
    set_mapping($urandom_range(0, 1023), $urandom_range(0, 1023));
    repeat (3) begin
      base = CODE_W'($urandom());
      span = $urandom_range(10, 16);
      for (int k = 0; k < span; k++) begin
        send_item(CMD_MARK, base + CODE_W'(k));
      end
      repeat (4) begin
        send_item($urandom_range(0, 1) ? CMD_SAMPLE : CMD_QUERY,
                  base + CODE_W'($urandom_range(0, span + 3)) - CODE_W'(2));
      end
    end
  endtask

  // The receiver stalls for a long stretch while commands keep coming, so a
  // finished result sits in the output register and the input stalls.
  task automatic test_output_backpressure();
    logic [CODE_W-1:0] code;
    code = CODE_W'($urandom());
    long_hold = 1'b1;
    repeat (8) begin
      code = pick_code(code);
      send_item(pick_cmd(), code);
    end
    wait_until_idle();
  endtask

  // Both sides without idle cycles, so commands follow each other as fast as
  // the block accepts them.
  task automatic test_back_to_back();
    logic [CODE_W-1:0] code;
    code = CODE_W'($urandom());
    steady_flow = 1'b1;
    repeat (40) begin
      code = pick_code(code);
      send_item(pick_cmd(), code);
    end
    wait_until_idle();
    steady_flow = 1'b0;
  endtask

  // Receiver: draws a stall before each result, or takes the long hold-off
  // once when asked. Like the sender, it changes ready only at falling edges.
  initial begin : receiver
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        stall = HOLD_CYCLES;
        long_hold = 1'b0;
        n_holds++;
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 3);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  function automatic void report_mismatch(string what, rank_result_t want,
                                          rank_result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("[%0t] %s: expected pos=%0d lower=%0d total=%0d seen=%0d, got pos=%0d lower=%0d total=%0d seen=%0d",
               $realtime, what, want.position, want.rank_lower, want.total_seen,
               want.seen_bit, got.position, got.rank_lower, got.total_seen,
               got.seen_bit);
    end
  endfunction

  // Checks every accepted result transaction against the oldest expectation,
  // field by field.
  always @(posedge clk) begin : check_results
    rank_result_t got;
    rank_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.position   = out_tdata[POS_W-1:0];
      got.rank_lower = out_tdata[POS_W +: COUNT_W];
      got.total_seen = out_tdata[POS_W + COUNT_W +: COUNT_W];
      got.seen_bit   = out_tdata[POS_W + 2 * COUNT_W];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.position !== want.position || got.rank_lower !== want.rank_lower
            || got.total_seen !== want.total_seen || got.seen_bit !== want.seen_bit) begin
          report_mismatch("field mismatch", want, got);
        end
      end
    end
  end

  // Watchdog: ends the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    quiet_cycles = 0;
    steady_flow  = 1'b0;
    long_hold    = 1'b0;
    mismatches   = 0;
    n_sample     = 0;
    n_mark       = 0;
    n_query      = 0;
    n_writes     = 0;
    n_holds      = 0;
    n_checked    = 0;
    peak_total   = 0;
    shadow_start = int'(OUT_START_RST);
    shadow_end   = int'(OUT_END_RST);
    foreach (seen_flags[i]) seen_flags[i] = 1'b0;

    // Synchronous reset, released at a falling edge.
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_register_extremes();
    test_random_traffic();
    test_calibration_restore();
    test_output_backpressure();
    test_back_to_back();

    // Everything has been accepted; wait for the last results, then leave room
    // for a stray result that should not appear.
    wait_until_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d results: %0d samples, %0d marks, %0d queries or spare commands.",
             n_checked, n_sample, n_mark, n_query);
    $display("Made %0d register writes and %0d long output stalls; bitmap peaked at %0d codes.",
             n_writes, n_holds, peak_total);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/scrl_pkg.sv
rtl/core/scrl_ram.sv
rtl/core/scrl_div.sv
rtl/core/seen_code_rank_linearizer_unit.sv
tb/tb_seen_code_rank_linearizer_unit.sv
